### rtl/aep_pkg.sv
// Shared types for the asymmetric error propagation ALU.
// Holds the operation and status codes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aep_pkg;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2
    } status_t;

endpackage

`default_nettype wire

### rtl/aep_in_if.sv
// Operand channel: valid/ready handshake with the operation and both operands.
// Depends on aep_pkg for the operation code.
`timescale 1ns / 1ps
`default_nettype none

interface aep_in_if #(
    parameter int VALUE_WIDTH = 32
) ();
    logic                          valid;
    logic                          ready;
    aep_pkg::op_t                  operation;
    logic signed [VALUE_WIDTH-1:0] a_mean;
    logic [VALUE_WIDTH-2:0]        a_err_up;
    logic [VALUE_WIDTH-2:0]        a_err_down;
    logic signed [VALUE_WIDTH-1:0] b_mean;
    logic [VALUE_WIDTH-2:0]        b_err_up;
    logic [VALUE_WIDTH-2:0]        b_err_down;

    modport source (
        output valid, operation, a_mean, a_err_up, a_err_down, b_mean, b_err_up, b_err_down,
        input  ready
    );

    modport sink (
        input  valid, operation, a_mean, a_err_up, a_err_down, b_mean, b_err_up, b_err_down,
        output ready
    );
endinterface

`default_nettype wire

### rtl/aep_out_if.sv
// Result channel: valid/ready handshake with mean, errors, compare flags and status.
// Depends on aep_pkg for the status code.
`timescale 1ns / 1ps
`default_nettype none

interface aep_out_if #(
    parameter int VALUE_WIDTH = 32
) ();
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] result_mean;
    logic [VALUE_WIDTH-2:0]        result_err_up;
    logic [VALUE_WIDTH-2:0]        result_err_down;
    logic                          mean_less;
    logic                          mean_equal;
    aep_pkg::status_t              status;

    modport source (
        output valid, result_mean, result_err_up, result_err_down, mean_less, mean_equal,
               status,
        input  ready
    );

    modport sink (
        input  valid, result_mean, result_err_up, result_err_down, mean_less, mean_equal,
               status,
        output ready
    );
endinterface

`default_nettype wire

### rtl/aep_dly.sv
// Enabled shift-register delay line used to keep side data aligned with long units.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module aep_dly #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

`default_nettype wire

### rtl/aep_div.sv
// Pipelined restoring divider: one quotient bit per stage, QW+1 stages in all.
// Flags a quotient that does not fit QW bits. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module aep_div #(
    parameter int NW = 49,
    parameter int DW = 32,
    parameter int QW = 32
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo,
    output logic          ovf
);

    localparam int HW = NW - QW;
    localparam int RW = ((HW > DW) ? HW : DW) + 1;

    logic [RW-1:0] rem_reg [0:QW-1];
    logic [QW-1:0] nlo_reg [0:QW-1];
    logic [DW-1:0] den_reg [0:QW-1];
    logic [QW-1:0] quo_reg [1:QW];
    logic          ovf_reg [0:QW];

    // overflow when the high part alone already reaches the divisor
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= RW'(num[NW-1:QW]);
            nlo_reg[0] <= num[QW-1:0];
            den_reg[0] <= den;
            ovf_reg[0] <= RW'(num[NW-1:QW]) >= RW'(den);
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_stage
        logic [RW-1:0] sh_w;
        logic          ge_w;

        assign sh_w = {rem_reg[k-1][RW-2:0], nlo_reg[k-1][QW-k]};
        assign ge_w = sh_w >= RW'(den_reg[k-1]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end

        if (k == 1)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    quo_reg[k] <= QW'(ge_w);
                end
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    quo_reg[k] <= {quo_reg[k-1][QW-2:0], ge_w};
                end
            end
        end

        if (k < QW)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge_w ? (sh_w - RW'(den_reg[k-1])) : sh_w;
                    nlo_reg[k] <= nlo_reg[k-1];
                    den_reg[k] <= den_reg[k-1];
                end
            end
        end
    end

    assign quo = quo_reg[QW];
    assign ovf = ovf_reg[QW];

endmodule

`default_nettype wire

### rtl/aep_isqrt.sv
// Pipelined floor square root: one root bit per stage, RW stages.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module aep_isqrt #(
    parameter int RW = 32
) (
    input  logic            clk,
    input  logic            en,
    input  logic [2*RW-1:0] rad,
    output logic [RW-1:0]   root
);

    localparam int MW = RW + 2;

    logic [MW-1:0]   rem_reg  [0:RW-2];
    logic [2*RW-1:0] rad_reg  [0:RW-2];
    logic [RW-1:0]   root_reg [0:RW-1];

    for (genvar j = 0; j < RW; j++)
    begin : g_stage
        localparam int I = RW - 1 - j;

        logic [MW-1:0]   rem_w;
        logic [RW-1:0]   root_w;
        logic [2*RW-1:0] rad_w;
        logic [MW-1:0]   sh_w;
        logic [MW-1:0]   trial_w;
        logic            ge_w;

        if (j == 0)
        begin : g_in
            assign rem_w  = '0;
            assign root_w = '0;
            assign rad_w  = rad;
        end
        else
        begin : g_prev
            assign rem_w  = rem_reg[j-1];
            assign root_w = root_reg[j-1];
            assign rad_w  = rad_reg[j-1];
        end

        assign sh_w    = {rem_w[MW-3:0], rad_w[2*I+1 -: 2]};
        assign trial_w = {root_w, 2'b01};
        assign ge_w    = sh_w >= trial_w;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[j] <= {root_w[RW-2:0], ge_w};
            end
        end

        if (j < RW - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j] <= ge_w ? (sh_w - trial_w) : sh_w;
                    rad_reg[j] <= rad_w;
                end
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule

`default_nettype wire

### rtl/asymmetric_error_propagation_alu.sv
// Usage
// Operands arrive on the operands channel (valid/ready): operation (add, subtract,
// multiply, divide), two signed fixed-point means and their unsigned upper and lower
// errors. Each item yields exactly one item on the results channel: the mean, both
// errors combined in quadrature, the less/equal compare of the input means, and a
// status (ok, saturated, divide by zero).
// Throughput: one item per clock cycle, sustained while results are not stalled.
// The path runs through decode, multiply, the divider pipeline (one quotient bit per
// stage, VALUE_WIDTH+1 stages), select, square and sum stages, then the square-root
// pipeline (one root bit per stage, VALUE_WIDTH stages) and the output register.
// Reset clears every valid bit; no item is in flight afterwards.
// A stall on the results channel freezes the whole pipeline in place and drops
// operands.ready in the same cycle; nothing is lost or repeated.
// Depends on aep_pkg, aep_in_if, aep_out_if, aep_dly, aep_div and aep_isqrt.
`timescale 1ns / 1ps
`default_nettype none

module asymmetric_error_propagation_alu #(
    parameter int FRAC_BITS   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    aep_in_if.sink   operands,
    aep_out_if.source results
);

    localparam int W   = VALUE_WIDTH;
    localparam int EW  = W - 1;
    localparam int F   = FRAC_BITS;
    localparam int PW  = 2 * W;
    localparam int TW  = PW - 1;
    localparam int SQW = 2 * EW;
    localparam int NMW = W + F + 1;
    localparam int NTW = TW + F;
    localparam int NV  = 2 * W + 6;

    localparam logic [W-1:0]  MEAN_MAX = {1'b0, {EW{1'b1}}};
    localparam logic [W-1:0]  MEAN_MIN = {1'b1, {EW{1'b0}}};
    localparam logic [EW-1:0] ERR_MAX  = {EW{1'b1}};

    typedef struct packed {
        aep_pkg::op_t op;
        logic         neg;
        logic         less;
        logic         equal;
        logic         bzero;
    } ctl_t;

    typedef struct packed {
        ctl_t                ctl;
        logic [W-1:0]        mean;
        logic                msat;
        logic [1:0][EW-1:0]  x;
        logic [1:0]          xo;
        logic [1:0][EW-1:0]  y;
        logic [1:0]          yo;
    } side_t;

    typedef struct packed {
        logic               less;
        logic               equal;
        logic               dz;
        logic               msat;
        logic [W-1:0]       mean;
        logic [1:0][EW-1:0] x;
        logic [1:0][EW-1:0] y;
        logic [1:0]         o;
    } mid_t;

    typedef struct packed {
        logic         less;
        logic         equal;
        logic         dz;
        logic         msat;
        logic [W-1:0] mean;
        logic [1:0]   o;
    } tail_t;

    // {saturated, value} of a signed mean given its magnitude and sign
    function automatic logic [W:0] sat_mean(input logic big, input logic [W-1:0] mag,
                                            input logic neg);
        logic [W:0] r;
        if (neg)
        begin
            if (big || (mag[W-1] && (|mag[W-2:0])))
                r = {1'b1, MEAN_MIN};
            else
                r = {1'b0, W'(~mag + 1'b1)};
        end
        else
        begin
            if (big || mag[W-1])
                r = {1'b1, MEAN_MAX};
            else
                r = {1'b0, mag};
        end
        return r;
    endfunction

    logic en;
    logic [NV-1:0] vld_reg;
    logic out_valid_reg;

    assign en             = !out_valid_reg || results.ready;
    assign operands.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[NV-2:0], operands.valid};
            out_valid_reg <= vld_reg[NV-1];
        end
    end

    // decode, add/subtract
    logic [W-1:0]  a_w;
    logic [W-1:0]  b_w;
    logic [W-1:0]  ma_w;
    logic [W-1:0]  mb_w;
    logic [W:0]    s_w;
    logic          s_ovf_w;
    logic [W-1:0]  as_mean_w;

    assign a_w  = operands.a_mean;
    assign b_w  = operands.b_mean;
    assign ma_w = a_w[W-1] ? W'(~a_w + 1'b1) : a_w;
    assign mb_w = b_w[W-1] ? W'(~b_w + 1'b1) : b_w;
    assign s_w  = (operands.operation == aep_pkg::OP_SUB) ?
                  ({a_w[W-1], a_w} - {b_w[W-1], b_w}) :
                  ({a_w[W-1], a_w} + {b_w[W-1], b_w});
    assign s_ovf_w   = s_w[W] != s_w[W-1];
    assign as_mean_w = s_ovf_w ? (s_w[W] ? MEAN_MIN : MEAN_MAX) : s_w[W-1:0];

    ctl_t          p1_ctl_reg;
    logic [W-1:0]  p1_ma_reg;
    logic [W-1:0]  p1_mb_reg;
    logic [EW-1:0] p1_ea_reg [2];
    logic [EW-1:0] p1_eb_reg [2];
    logic [W-1:0]  p1_as_mean_reg;
    logic          p1_as_sat_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_ctl_reg.op    <= operands.operation;
            p1_ctl_reg.neg   <= a_w[W-1] ^ b_w[W-1];
            p1_ctl_reg.less  <= $signed(a_w) < $signed(b_w);
            p1_ctl_reg.equal <= a_w == b_w;
            p1_ctl_reg.bzero <= b_w == '0;
            p1_ma_reg        <= ma_w;
            p1_mb_reg        <= mb_w;
            p1_ea_reg[0]     <= operands.a_err_up;
            p1_ea_reg[1]     <= operands.a_err_down;
            p1_eb_reg[0]     <= operands.b_err_up;
            p1_eb_reg[1]     <= operands.b_err_down;
            p1_as_mean_reg   <= as_mean_w;
            p1_as_sat_reg    <= s_ovf_w;
        end
    end

    // products
    ctl_t          p2_ctl_reg;
    logic [W-1:0]  p2_ma_reg;
    logic [W-1:0]  p2_mb_reg;
    logic [EW-1:0] p2_ea_reg [2];
    logic [EW-1:0] p2_eb_reg [2];
    logic [W-1:0]  p2_as_mean_reg;
    logic          p2_as_sat_reg;
    logic [PW-1:0] p2_pm_reg;
    logic [PW-1:0] p2_bsq_reg;
    logic [TW-1:0] p2_t1p_reg [2];
    logic [TW-1:0] p2_t2p_reg [2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_ctl_reg     <= p1_ctl_reg;
            p2_ma_reg      <= p1_ma_reg;
            p2_mb_reg      <= p1_mb_reg;
            p2_as_mean_reg <= p1_as_mean_reg;
            p2_as_sat_reg  <= p1_as_sat_reg;
            p2_pm_reg      <= PW'(p1_ma_reg) * PW'(p1_mb_reg);
            p2_bsq_reg     <= PW'(p1_mb_reg) * PW'(p1_mb_reg);
            for (int k = 0; k < 2; k++)
            begin
                p2_ea_reg[k]  <= p1_ea_reg[k];
                p2_eb_reg[k]  <= p1_eb_reg[k];
                p2_t1p_reg[k] <= TW'(p1_mb_reg) * TW'(p1_ea_reg[k]);
                p2_t2p_reg[k] <= TW'(p1_ma_reg) * TW'(p1_eb_reg[k]);
            end
        end
    end

    // dividers
    logic [NMW-1:0] num_m_w;
    logic [W-1:0]   dq_m_w;
    logic           dov_m_w;
    logic [W-1:0]   dq_t1_w [2];
    logic           dov_t1_w [2];
    logic [W-1:0]   dq_t2_w [2];
    logic           dov_t2_w [2];

    assign num_m_w = NMW'(p2_ma_reg) << F;

    aep_div #(.NW(NMW), .DW(W), .QW(W)) u_div_mean (
        .clk (clk),
        .en  (en),
        .num (num_m_w),
        .den (p2_mb_reg),
        .quo (dq_m_w),
        .ovf (dov_m_w)
    );

    for (genvar k = 0; k < 2; k++)
    begin : g_div
        logic [NMW-1:0] num_t1_w;
        logic [NTW-1:0] num_t2_w;

        assign num_t1_w = NMW'(p2_ea_reg[k]) << F;
        assign num_t2_w = NTW'(p2_t2p_reg[k]) << F;

        aep_div #(.NW(NMW), .DW(W), .QW(W)) u_div_t1 (
            .clk (clk),
            .en  (en),
            .num (num_t1_w),
            .den (p2_mb_reg),
            .quo (dq_t1_w[k]),
            .ovf (dov_t1_w[k])
        );

        aep_div #(.NW(NTW), .DW(PW), .QW(W)) u_div_t2 (
            .clk (clk),
            .en  (en),
            .num (num_t2_w),
            .den (p2_bsq_reg),
            .quo (dq_t2_w[k]),
            .ovf (dov_t2_w[k])
        );
    end

    // add/subtract and multiply results, held beside the dividers
    side_t          side_next;
    side_t          side_dly;
    logic [PW-1:0]  mul_sh_w;
    logic [W:0]     mul_mr_w;
    logic [TW-1:0]  t1s_w [2];
    logic [TW-1:0]  t2s_w [2];

    assign mul_sh_w = p2_pm_reg >> F;
    assign mul_mr_w = sat_mean(|mul_sh_w[PW-1:W], mul_sh_w[W-1:0], p2_ctl_reg.neg);

    always_comb
    begin
        side_next.ctl  = p2_ctl_reg;
        side_next.mean = p2_as_mean_reg;
        side_next.msat = p2_as_sat_reg;
        for (int k = 0; k < 2; k++)
        begin
            t1s_w[k]        = p2_t1p_reg[k] >> F;
            t2s_w[k]        = p2_t2p_reg[k] >> F;
            side_next.x[k]  = p2_ea_reg[k];
            side_next.xo[k] = 1'b0;
            side_next.y[k]  = p2_eb_reg[k];
            side_next.yo[k] = 1'b0;
        end
        if (p2_ctl_reg.op == aep_pkg::OP_MUL)
        begin
            side_next.mean = mul_mr_w[W-1:0];
            side_next.msat = mul_mr_w[W];
            for (int k = 0; k < 2; k++)
            begin
                side_next.x[k]  = t1s_w[k][EW-1:0];
                side_next.xo[k] = |t1s_w[k][TW-1:EW];
                side_next.y[k]  = t2s_w[k][EW-1:0];
                side_next.yo[k] = |t2s_w[k][TW-1:EW];
            end
        end
    end

    aep_dly #(.WIDTH($bits(side_t)), .DEPTH(W + 1)) u_side_dly (
        .clk  (clk),
        .en   (en),
        .din  (side_next),
        .dout (side_dly)
    );

    // select per operation
    mid_t       p4_next;
    mid_t       p4_reg;
    logic [W:0] div_mr_w;

    assign div_mr_w = sat_mean(dov_m_w, dq_m_w, side_dly.ctl.neg);

    always_comb
    begin
        p4_next.less  = side_dly.ctl.less;
        p4_next.equal = side_dly.ctl.equal;
        p4_next.dz    = 1'b0;
        p4_next.msat  = side_dly.msat;
        p4_next.mean  = side_dly.mean;
        p4_next.x     = side_dly.x;
        p4_next.y     = side_dly.y;
        p4_next.o     = side_dly.xo | side_dly.yo;
        if (side_dly.ctl.op == aep_pkg::OP_DIV)
        begin
            if (side_dly.ctl.bzero)
            begin
                p4_next.dz   = 1'b1;
                p4_next.msat = 1'b0;
                p4_next.mean = MEAN_MAX;
                p4_next.o    = 2'b11;
            end
            else
            begin
                p4_next.mean = div_mr_w[W-1:0];
                p4_next.msat = div_mr_w[W];
                for (int k = 0; k < 2; k++)
                begin
                    p4_next.x[k] = dq_t1_w[k][EW-1:0];
                    p4_next.y[k] = dq_t2_w[k][EW-1:0];
                    p4_next.o[k] = dov_t1_w[k] | dq_t1_w[k][W-1] |
                                   dov_t2_w[k] | dq_t2_w[k][W-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p4_reg <= p4_next;
        end
    end

    // squares, then sums
    tail_t          p5_tail_reg;
    logic [SQW-1:0] p5_xs_reg [2];
    logic [SQW-1:0] p5_ys_reg [2];
    tail_t          p6_tail_reg;
    logic [PW-1:0]  p6_sum_reg [2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p5_tail_reg.less  <= p4_reg.less;
            p5_tail_reg.equal <= p4_reg.equal;
            p5_tail_reg.dz    <= p4_reg.dz;
            p5_tail_reg.msat  <= p4_reg.msat;
            p5_tail_reg.mean  <= p4_reg.mean;
            p5_tail_reg.o     <= p4_reg.o;
            p6_tail_reg       <= p5_tail_reg;
            for (int k = 0; k < 2; k++)
            begin
                p5_xs_reg[k]  <= SQW'(p4_reg.x[k]) * SQW'(p4_reg.x[k]);
                p5_ys_reg[k]  <= SQW'(p4_reg.y[k]) * SQW'(p4_reg.y[k]);
                p6_sum_reg[k] <= PW'(p5_xs_reg[k]) + PW'(p5_ys_reg[k]);
            end
        end
    end

    // square roots
    logic [W-1:0] root_w [2];
    tail_t        tail_dly;

    for (genvar k = 0; k < 2; k++)
    begin : g_sqrt
        aep_isqrt #(.RW(W)) u_isqrt (
            .clk  (clk),
            .en   (en),
            .rad  (p6_sum_reg[k]),
            .root (root_w[k])
        );
    end

    aep_dly #(.WIDTH($bits(tail_t)), .DEPTH(W)) u_tail_dly (
        .clk  (clk),
        .en   (en),
        .din  (p6_tail_reg),
        .dout (tail_dly)
    );

    // output register
    logic              esat_w [2];
    logic [EW-1:0]     err_next [2];
    aep_pkg::status_t  status_next;

    logic [W-1:0]      out_mean_reg;
    logic [EW-1:0]     out_err_up_reg;
    logic [EW-1:0]     out_err_down_reg;
    logic              out_less_reg;
    logic              out_equal_reg;
    aep_pkg::status_t  out_status_reg;

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            esat_w[k]   = tail_dly.o[k] | root_w[k][W-1];
            err_next[k] = esat_w[k] ? ERR_MAX : root_w[k][EW-1:0];
        end
        if (tail_dly.dz)
            status_next = aep_pkg::ST_DIVZ;
        else if (tail_dly.msat || esat_w[0] || esat_w[1])
            status_next = aep_pkg::ST_SAT;
        else
            status_next = aep_pkg::ST_OK;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_mean_reg     <= tail_dly.mean;
            out_err_up_reg   <= err_next[0];
            out_err_down_reg <= err_next[1];
            out_less_reg     <= tail_dly.less;
            out_equal_reg    <= tail_dly.equal;
            out_status_reg   <= status_next;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.result_mean     = out_mean_reg;
    assign results.result_err_up   = out_err_up_reg;
    assign results.result_err_down = out_err_down_reg;
    assign results.mean_less       = out_less_reg;
    assign results.mean_equal      = out_equal_reg;
    assign results.status          = out_status_reg;

`ifndef SYNTHESIS
    a_divz_fill: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.status == aep_pkg::ST_DIVZ |->
        results.result_mean == MEAN_MAX && results.result_err_up == ERR_MAX &&
        results.result_err_down == ERR_MAX)
        else $error("divide by zero result not at full scale");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> !(results.mean_less && results.mean_equal))
        else $error("less and equal both set");

    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.ready |-> !operands.ready)
        else $error("operands taken while results stalled");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_reg[NV-1] |=> results.valid)
        else $error("item lost at output register");
`endif

endmodule

`default_nettype wire
